>>> sv/sle_pkg.sv
// Shared types and constants for the sorted list engine.
// Holds operation and status codes, controller states and the command/status structs.
// No dependencies.
package sle_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DATA_W           = 32;
    localparam int POS_W            = 6;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 7;

    // operation codes; the fourth code is unused and reported as bad index
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_CMP,
        S_R_RD,
        S_R_WR,
        S_PLACE,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture a new request
        logic set_err;     // record bad index or full status
        logic rd;          // read entry at idx
        logic rd_next;     // read entry at idx+1
        logic shift_up;    // entry[idx+1] = read data, idx--
        logic shift_down;  // entry[idx] = read data, idx++
        logic place;       // entry[idx+1] = value, count++
        logic capture;     // result data = read data
        logic dec;         // count--
        logic emit;        // load the output register
    } sle_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_insert;
        logic op_get;
        logic op_remove;
        logic bad_req;     // get/remove past the end, or any code other than get/remove (also set for insert)
        logic full;
        logic idx_neg;     // insert walk has gone below the first entry
        logic idx_zero;
        logic hit;         // read entry is not less than the value
        logic at_last;     // idx+1 == count
        logic next_last;   // idx+2 == count
        logic out_free;    // output register can take a result
    } sle_stat_t;

endpackage

>>> sv/sle_ctrl.sv
// Controller state machine for the sorted list engine.
// Sequences the memory walk for insert, get and remove. Depends on sle_pkg.
module sle_ctrl
    import sle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  sle_stat_t stat,
    output sle_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.op_insert)
                begin
                    if (stat.full)
                        state_next = S_FINISH;
                    else if (stat.idx_neg)
                        state_next = S_PLACE;
                    else
                        state_next = S_READ;
                end
                else if (stat.bad_req)
                    state_next = S_FINISH;
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.op_insert)
                begin
                    if (stat.hit)
                        state_next = stat.idx_zero ? S_PLACE : S_READ;
                    else
                        state_next = S_FINISH;
                end
                else if (stat.op_remove && !stat.at_last)
                    state_next = S_R_RD;
                else
                    state_next = S_FINISH;
            end
            S_R_RD:
            begin
                state_next = S_R_WR;
            end
            S_R_WR:
            begin
                state_next = stat.next_last ? S_FINISH : S_R_RD;
            end
            S_PLACE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_CHECK:
            begin
                if (stat.op_insert)
                    cmd.set_err = stat.full;
                else
                    cmd.set_err = stat.bad_req;
            end
            S_READ:
            begin
                cmd.rd = 1'b1;
            end
            S_CMP:
            begin
                if (stat.op_insert)
                begin
                    cmd.shift_up = stat.hit;
                    cmd.place    = !stat.hit;
                end
                else
                begin
                    cmd.capture = 1'b1;
                    cmd.dec     = stat.op_remove && stat.at_last;
                end
            end
            S_R_RD:
            begin
                cmd.rd_next = 1'b1;
            end
            S_R_WR:
            begin
                cmd.shift_down = 1'b1;
                cmd.dec        = stat.next_last;
            end
            S_PLACE:
            begin
                cmd.place = 1'b1;
            end
            S_FINISH:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/sle_datapath.sv
// Datapath for the sorted list engine: entry memory, count, walk index,
// request and result registers. Depends on sle_pkg.
module sle_datapath
    import sle_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [DATA_W-1:0]   value,
    input  logic [POS_W-1:0]           position,
    input  sle_cmd_t                   cmd,
    output sle_stat_t                  stat,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DATA_W-1:0]   data,
    output logic [STATUS_W-1:0]        status,
    output logic [COUNT_W-1:0]         count
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 2;

    logic [DATA_W-1:0]          mem [CAPACITY];
    logic [DATA_W-1:0]          rd_data_reg;

    logic [OP_W-1:0]            op_reg;
    logic signed [DATA_W-1:0]   val_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [AW:0]                idx_reg;
    logic [AW:0]                idx_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;

    logic signed [DATA_W-1:0]   res_data_reg;
    logic [STATUS_W-1:0]        res_status_reg;
    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   out_data_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic [COUNT_W-1:0]         out_count_reg;

    logic [AW-1:0]              idx_lo;
    logic [AW-1:0]              idx_up;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [DATA_W-1:0]          wr_data;
    logic [CMPW-1:0]            idx_w;
    logic [CMPW-1:0]            count_w;
    logic [CMPW-1:0]            pos_w;

    assign idx_lo  = idx_reg[AW-1:0];
    assign idx_up  = AW'(idx_reg + 1'b1);
    assign idx_w   = CMPW'(idx_reg);
    assign count_w = CMPW'(count_reg);
    assign pos_w   = CMPW'(pos_reg);

    // status to controller
    always_comb
    begin
        stat           = '0;
        stat.op_insert = (op_reg == OP_INSERT);
        stat.op_get    = (op_reg == OP_GET);
        stat.op_remove = (op_reg == OP_REMOVE);
        stat.bad_req   = !(stat.op_get || stat.op_remove) || !stat.op_insert && (pos_w >= count_w);
        stat.full      = (count_w == CMPW'(CAPACITY));
        stat.idx_neg   = idx_reg[AW];
        stat.idx_zero  = (idx_reg == '0);
        stat.hit       = ($signed(rd_data_reg) >= val_reg);
        stat.at_last   = ((idx_w + 1'b1) == count_w);
        stat.next_last = ((idx_w + 2'd2) == count_w);
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    // memory port selection
    always_comb
    begin
        rd_addr = cmd.rd_next ? idx_up : idx_lo;
        wr_en   = cmd.shift_up || cmd.shift_down || cmd.place;
        wr_addr = cmd.shift_down ? idx_lo : idx_up;
        wr_data = cmd.place ? DATA_W'(val_reg) : rd_data_reg;
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd || cmd.rd_next)
            rd_data_reg <= mem[rd_addr];
    end

    // walk index and entry count
    always_comb
    begin
        idx_next   = idx_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            if (op_t'(operation) == OP_INSERT)
                idx_next = (AW+1)'(count_reg) - 1'b1;
            else
                idx_next = (AW+1)'(position);
        end
        else if (cmd.shift_up)
            idx_next = idx_reg - 1'b1;
        else if (cmd.shift_down)
            idx_next = idx_reg + 1'b1;
        if (cmd.place)
            count_next = count_reg + 1'b1;
        else if (cmd.dec)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // request and result registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            op_reg         <= operation;
            val_reg        <= value;
            pos_reg        <= position;
            res_data_reg   <= '0;
            res_status_reg <= ST_OK;
        end
        if (cmd.set_err)
            res_status_reg <= stat.op_insert ? ST_FULL : ST_BAD_INDEX;
        if (cmd.capture)
            res_data_reg <= $signed(rd_data_reg);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg   <= res_data_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= COUNT_W'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = out_data_reg;
    assign status    = out_status_reg;
    assign count     = out_count_reg;

endmodule

>>> sv/sorted_list_engine.sv
// Sorted list engine: ascending list of signed words with insert, get and remove.
// Get reads one entry; insert and remove move entries one at a time, each moved entry
// read and then written, and an insert on an empty list writes its value without a read;
// a full insert, bad position or unused code skips the memory. One request in flight: the
// next is taken in the cycle after the result is loaded, later while the result is stalled.
// Reset empties the list at once (count to zero); entry contents are not cleared.
module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [DATA_W-1:0]   value,
    input  logic [POS_W-1:0]           position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DATA_W-1:0]   data,
    output logic [STATUS_W-1:0]        status,
    output logic [COUNT_W-1:0]         count
);

    sle_cmd_t  cmd;
    sle_stat_t stat;

    sle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (operation),
        .value     (value),
        .position  (position),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data      (data),
        .status    (status),
        .count     (count)
    );

endmodule
